// ----- design/emt_pkg.sv -----
// types and codes shared by the extent map translate block
package emt_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_MERGED   = 3'd0,
		ST_APPENDED = 3'd1,
		ST_FULL     = 3'd2,
		ST_REJECT   = 3'd3,
		ST_HIT      = 3'd4,
		ST_MISS     = 3'd5,
		ST_CLEARED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPEND,
		S_LOOKUP
	} state_t;

	typedef struct packed {
		logic [31:0] logical;
		logic [31:0] physical;
		logic [31:0] length;
	} ext_entry_t;

endpackage

// ----- design/emt_ram.sv -----
// generic single-write, single-read ram with registered read data
module emt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/extent_map_translate_core.sv -----
// extent map translate core: sorted extent table with append and binary-search lookup
//
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------------
// command   | start, busy           | op, logical_block, physical_block, run_blocks
// result    | done (one-cycle)      | status, mapped_block, hit_logical_start,
//           |                       | hit_physical_start, hit_length, entries_used
//
// a command transfer happens on a rising edge with start high and busy low
// clear, zero-length append, append to an empty table and lookup in an empty table:
//   done in the cycle after the transfer, busy never rises; an unused op gives no result
// other appends: one ram read of the last extent, checked in S_APPEND; done is registered from there
// lookup: one ram read per binary-search probe on the single ram read port, so
//   ceil(log2(n+1)) probes at most for n entries (7 for a full table of 64)
// reset clears the fsm, the entry count and the strobe; the table itself is never cleared
// the receiver cannot stall: done is high for exactly one cycle, the payload holds until the next result
module extent_map_translate_core #(
	parameter int MAX_EXTENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] logical_block,
	input  logic [31:0] physical_block,
	input  logic [31:0] run_blocks,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] mapped_block,
	output logic [31:0] hit_logical_start,
	output logic [31:0] hit_physical_start,
	output logic [31:0] hit_length,
	output logic [6:0]  entries_used
);

	import emt_pkg::*;

	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	// midpoint of the inclusive range lo .. he-1, rounded down
	function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] he);
		logic [CW:0] sum;
		sum = {1'b0, lo} + {1'b0, he} - (CW+1)'(1);
		return sum[CW:1];
	endfunction

	// control state
	state_t       state_q, state_n;
	logic [CW-1:0] count_q, count_n;
	logic         done_q;

	// command held for the multi-cycle ops
	logic [31:0]  lb_q, pb_q, len_q;

	// search window: lo inclusive, he exclusive, and the entry being probed
	logic [CW-1:0] lo_q, lo_n, he_q, he_n, mid_q, mid_n;

	// result registers
	logic         res_load;
	status_t      res_status, status_q;
	logic [31:0]  res_mapped, mapped_q;
	ext_entry_t   res_ext, ext_q;
	logic [CW-1:0] res_count, used_q;

	// table ram port
	logic         we;
	logic [AW-1:0] waddr, raddr;
	ext_entry_t   wdata, rdata;

	// working values
	logic         accept;
	logic [CW-1:0] last_cnt;
	logic [AW-1:0] last_idx;
	logic [CW-1:0] mid_first;
	logic [32:0]  log_end, phy_end, len_sum;
	logic         merge_ok;
	logic         below, above;

	assign accept    = start && !busy;
	assign last_cnt  = count_q - CW'(1);
	assign last_idx  = last_cnt[AW-1:0];
	// first probe of a lookup over the whole table
	assign mid_first = mid_of('0, count_q);

	// append checks against the last extent (ends taken without wrap)
	assign log_end  = {1'b0, rdata.logical} + {1'b0, rdata.length};
	assign phy_end  = {1'b0, rdata.physical} + {1'b0, rdata.length};
	assign len_sum  = {1'b0, rdata.length} + {1'b0, len_q};
	assign merge_ok = (log_end == {1'b0, lb_q}) && (phy_end == {1'b0, pb_q}) && !len_sum[32];

	// lookup compare of the probed extent, reusing the logical end sum
	assign below = lb_q < rdata.logical;
	assign above = {1'b0, lb_q} >= log_end;

	emt_ram #(
		.WIDTH ($bits(ext_entry_t)),
		.DEPTH (MAX_EXTENTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_n    = state_q;
		count_n    = count_q;
		lo_n       = lo_q;
		he_n       = he_q;
		mid_n      = mid_q;
		we         = 1'b0;
		waddr      = last_idx;
		wdata      = '{logical: lb_q, physical: pb_q, length: len_q};
		raddr      = last_idx;
		res_load   = 1'b0;
		res_status = ST_MISS;
		res_mapped = '0;
		res_ext    = '0;
		res_count  = count_q;

		unique case (state_q)
			S_IDLE: begin
				// the ram read starts here so the data is ready in the next state
				if (op == OP_LOOKUP) begin
					raddr = mid_first[AW-1:0];
				end
				if (accept) begin
					case (op)
						OP_CLEAR: begin
							count_n    = '0;
							res_load   = 1'b1;
							res_status = ST_CLEARED;
							res_count  = '0;
						end
						OP_APPEND: begin
							if (run_blocks == '0) begin
								res_load   = 1'b1;
								res_status = ST_REJECT;
							end else if (count_q == '0) begin
								// empty table: first extent goes straight to entry 0
								we         = 1'b1;
								waddr      = '0;
								wdata      = '{logical: logical_block, physical: physical_block,
								               length: run_blocks};
								count_n    = CW'(1);
								res_load   = 1'b1;
								res_status = ST_APPENDED;
								res_ext    = wdata;
								res_count  = CW'(1);
							end else begin
								state_n = S_APPEND;
							end
						end
						OP_LOOKUP: begin
							if (count_q == '0) begin
								res_load   = 1'b1;
								res_status = ST_MISS;
							end else begin
								lo_n    = '0;
								he_n    = count_q;
								mid_n   = mid_first;
								state_n = S_LOOKUP;
							end
						end
						default: begin
							// unused op: taken and dropped, no result
						end
					endcase
				end
			end

			S_APPEND: begin
				res_load = 1'b1;
				state_n  = S_IDLE;
				if (merge_ok) begin
					we         = 1'b1;
					waddr      = last_idx;
					wdata      = '{logical: rdata.logical, physical: rdata.physical,
					               length: len_sum[31:0]};
					res_status = ST_MERGED;
					res_ext    = wdata;
				end else if (lb_q <= rdata.logical) begin
					res_status = ST_REJECT;
				end else if (count_q >= CW'(MAX_EXTENTS)) begin
					res_status = ST_FULL;
				end else begin
					we         = 1'b1;
					waddr      = count_q[AW-1:0];
					count_n    = count_q + CW'(1);
					res_status = ST_APPENDED;
					res_ext    = wdata;
					res_count  = count_q + CW'(1);
				end
			end

			S_LOOKUP: begin
				if (!below && !above) begin
					res_load   = 1'b1;
					res_status = ST_HIT;
					res_mapped = rdata.physical + (lb_q - rdata.logical);
					res_ext    = rdata;
					state_n    = S_IDLE;
				end else begin
					// narrow the window and issue the read for the next probe in the same cycle
					if (above) begin
						lo_n = mid_q + CW'(1);
					end
					if (below) begin
						he_n = mid_q;
					end
					if (lo_n < he_n) begin
						mid_n = mid_of(lo_n, he_n);
						raddr = mid_n[AW-1:0];
					end else begin
						res_load   = 1'b1;
						res_status = ST_MISS;
						state_n    = S_IDLE;
					end
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			done_q  <= res_load;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lb_q  <= logical_block;
			pb_q  <= physical_block;
			len_q <= run_blocks;
		end
		lo_q  <= lo_n;
		he_q  <= he_n;
		mid_q <= mid_n;
		if (res_load) begin
			status_q <= res_status;
			mapped_q <= res_mapped;
			ext_q    <= res_ext;
			used_q   <= res_count;
		end
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign status             = status_q;
	assign mapped_block       = mapped_q;
	assign hit_logical_start  = ext_q.logical;
	assign hit_physical_start = ext_q.physical;
	assign hit_length         = ext_q.length;
	// count reported modulo 128
	assign entries_used       = 7'(used_q);

	// a result only shows once the fsm is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the table never holds more entries than it has room for
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_EXTENTS))
		else $error("entry count beyond table size");

	// every probe lies inside a non-empty search window
	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP) |-> (lo_q < he_q) && (mid_q >= lo_q) && (mid_q < he_q))
		else $error("lookup probe outside its window");

	// an unused op transfer gives no result
	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op != OP_CLEAR && op != OP_APPEND && op != OP_LOOKUP) |=> !done)
		else $error("result for an unused op");

endmodule
